FILE: hw/rtl/tcgd_pkg.sv
// shared types and constants of the circle gesture detector
`default_nettype none

package tcgd_pkg;

    localparam int RING_DEPTH = 14;
    localparam int CNT_W      = $clog2(RING_DEPTH);
    localparam int SUM_W      = 16 + $clog2(RING_DEPTH);
    localparam int CMP_W      = ((SUM_W > 19) ? SUM_W : 19) + 1;

    localparam logic [7:0] CENTRE_X    = 8'h80;
    localparam logic [7:0] CENTRE_Y    = 8'h60;
    localparam logic [8:0] SUM_CENTRE  = 9'h0E0;
    localparam logic [8:0] DIFF_CENTRE = 9'h020;

    localparam logic [17:0] TURN_THRESHOLD_RST = 18'd54613;
    localparam logic [14:0] DELTA_CLAMP_RST    = 15'd10923;
    localparam logic [8:0]  MIN_AXIS_SPAN_RST  = 9'd50;
    localparam logic [9:0]  MIN_DIAG_SPAN_RST  = 10'd70;

    typedef enum logic [1:0] {
        CFG_TURN_THRESHOLD = 2'd0,
        CFG_DELTA_CLAMP    = 2'd1,
        CFG_MIN_AXIS_SPAN  = 2'd2,
        CFG_MIN_DIAG_SPAN  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        GEST_NONE = 2'd0,
        GEST_NEG  = 2'd1,
        GEST_POS  = 2'd2
    } gesture_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] delta;
        logic [7:0]  x;
        logic [7:0]  y;
    } entry_t;

    typedef struct packed {
        logic [17:0] turn_threshold;
        logic [8:0]  min_axis_span;
        logic [9:0]  min_diag_span;
    } scan_cfg_t;

    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctrl_t;

    localparam entry_t IDLE_ENTRY = '{delta: 16'h0000, x: CENTRE_X, y: CENTRE_Y};

endpackage

`default_nettype wire

FILE: hw/rtl/tcgd_cell.sv
// one ring slot of the sample chain: delta and touch point
`default_nettype none

module tcgd_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire tcgd_pkg::entry_t din,
    output tcgd_pkg::entry_t      dout
);
    import tcgd_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= IDLE_ENTRY;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign dout = entry_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcgd_scan.sv
// accumulator at the chain tail: delta sum, point extents and the decision
`default_nettype none

module tcgd_scan (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tcgd_pkg::scan_ctrl_t ctrl,
    input  wire tcgd_pkg::entry_t     tail,
    input  wire tcgd_pkg::scan_cfg_t  cfg,
    output tcgd_pkg::gesture_t        result
);
    import tcgd_pkg::*;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [7:0] xmin_reg, xmin_next, xmax_reg, xmax_next;
    logic [7:0] ymin_reg, ymin_next, ymax_reg, ymax_next;
    logic [8:0] smin_reg, smin_next, smax_reg, smax_next;
    logic signed [8:0] dmin_reg, dmin_next, dmax_reg, dmax_next;

    logic [8:0]        s_val;
    logic signed [8:0] d_val;
    logic signed [CMP_W-1:0] sum_ext;
    logic signed [CMP_W-1:0] thr_ext;
    logic [7:0]  x_span;
    logic [7:0]  y_span;
    logic [8:0]  s_span;
    logic signed [9:0] d_span;
    logic        spans_ok;

    always_comb
    begin
        s_val = {1'b0, tail.x} + {1'b0, tail.y};
        d_val = $signed({1'b0, tail.x}) - $signed({1'b0, tail.y});

        sum_next  = sum_reg;
        xmin_next = xmin_reg;
        xmax_next = xmax_reg;
        ymin_next = ymin_reg;
        ymax_next = ymax_reg;
        smin_next = smin_reg;
        smax_next = smax_reg;
        dmin_next = dmin_reg;
        dmax_next = dmax_reg;

        if (ctrl.clear)
        begin
            sum_next  = '0;
            xmin_next = CENTRE_X;
            xmax_next = CENTRE_X;
            ymin_next = CENTRE_Y;
            ymax_next = CENTRE_Y;
            smin_next = SUM_CENTRE;
            smax_next = SUM_CENTRE;
            dmin_next = $signed(DIFF_CENTRE);
            dmax_next = $signed(DIFF_CENTRE);
        end
        else if (ctrl.step)
        begin
            sum_next = sum_reg + SUM_W'($signed(tail.delta));
            if (tail.x < xmin_reg) xmin_next = tail.x;
            if (tail.x > xmax_reg) xmax_next = tail.x;
            if (tail.y < ymin_reg) ymin_next = tail.y;
            if (tail.y > ymax_reg) ymax_next = tail.y;
            if (s_val < smin_reg)  smin_next = s_val;
            if (s_val > smax_reg)  smax_next = s_val;
            if (d_val < dmin_reg)  dmin_next = d_val;
            if (d_val > dmax_reg)  dmax_next = d_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            xmin_reg <= CENTRE_X;
            xmax_reg <= CENTRE_X;
            ymin_reg <= CENTRE_Y;
            ymax_reg <= CENTRE_Y;
            smin_reg <= SUM_CENTRE;
            smax_reg <= SUM_CENTRE;
            dmin_reg <= $signed(DIFF_CENTRE);
            dmax_reg <= $signed(DIFF_CENTRE);
        end
        else
        begin
            sum_reg  <= sum_next;
            xmin_reg <= xmin_next;
            xmax_reg <= xmax_next;
            ymin_reg <= ymin_next;
            ymax_reg <= ymax_next;
            smin_reg <= smin_next;
            smax_reg <= smax_next;
            dmin_reg <= dmin_next;
            dmax_reg <= dmax_next;
        end
    end

    // threshold compare and span check
    always_comb
    begin
        sum_ext = CMP_W'(sum_reg);
        thr_ext = $signed(CMP_W'(cfg.turn_threshold));
        x_span  = xmax_reg - xmin_reg;
        y_span  = ymax_reg - ymin_reg;
        s_span  = smax_reg - smin_reg;
        d_span  = 10'(dmax_reg) - 10'(dmin_reg);

        spans_ok = ({1'b0, x_span} >= cfg.min_axis_span) &&
                   ({1'b0, y_span} >= cfg.min_axis_span) &&
                   ({1'b0, s_span} >= cfg.min_diag_span) &&
                   ($unsigned(d_span) >= cfg.min_diag_span);

        result = GEST_NONE;
        if (sum_ext < -thr_ext)
        begin
            result = spans_ok ? GEST_NEG : GEST_NONE;
        end
        else if (sum_ext > thr_ext)
        begin
            result = spans_ok ? GEST_POS : GEST_NONE;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/touch_circle_gesture_detector.sv
// top level of the circle gesture detector: config, sequencer, cell chain
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid/in_stall  | enable, touch_held, angle_now, angle_prev, x, y
//  out     | out_valid/out_stall| gesture
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// each beat shifts the sample into the chain, rotates every slot past the
// accumulator, then decides; the rotation through the single accumulator
// sets the length of a beat, and the decision waits while out_stall holds
// a full output register; the result waits there while the next beat is taken
// reset puts the centre point and zero delta into every slot, no clearing pass
`default_nettype none

module touch_circle_gesture_detector (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic               enable,
    input  wire logic               touch_held,
    input  wire logic signed [15:0] angle_now,
    input  wire logic signed [15:0] angle_prev,
    input  wire logic [7:0]         touch_x,
    input  wire logic [7:0]         touch_y,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [1:0]         gesture,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [17:0]        cfg_data
);
    import tcgd_pkg::*;

    logic [17:0] turn_threshold_reg;
    logic [14:0] delta_clamp_reg;
    logic [8:0]  min_axis_span_reg;
    logic [9:0]  min_diag_span_reg;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    gesture_t   last_gesture_reg, last_gesture_next;
    logic       out_valid_reg, out_valid_next;
    gesture_t   gesture_reg, gesture_next;

    logic       accept;
    logic       rotate;
    logic       shift;
    logic       idle_sample;
    logic [15:0] raw_delta;
    logic signed [16:0] delta17;
    logic signed [16:0] lim17;
    logic [15:0] clamped;
    entry_t     new_entry;
    entry_t     chain [RING_DEPTH];
    entry_t     head_din;
    scan_ctrl_t scan_ctrl;
    scan_cfg_t  scan_cfg;
    gesture_t   scan_result;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_threshold_reg <= TURN_THRESHOLD_RST;
            delta_clamp_reg    <= DELTA_CLAMP_RST;
            min_axis_span_reg  <= MIN_AXIS_SPAN_RST;
            min_diag_span_reg  <= MIN_DIAG_SPAN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TURN_THRESHOLD: turn_threshold_reg <= cfg_data;
                CFG_DELTA_CLAMP:    delta_clamp_reg    <= cfg_data[14:0];
                CFG_MIN_AXIS_SPAN:  min_axis_span_reg  <= cfg_data[8:0];
                CFG_MIN_DIAG_SPAN:  min_diag_span_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // sample formation
    always_comb
    begin
        idle_sample = !enable || !touch_held || (last_gesture_reg != GEST_NONE);
        raw_delta   = angle_now - angle_prev;
        delta17     = $signed({raw_delta[15], raw_delta});
        lim17       = $signed({2'b00, delta_clamp_reg});
        clamped     = raw_delta;
        if (delta17 < -lim17)
        begin
            clamped = 16'((-lim17));
        end
        else if (delta17 > lim17)
        begin
            clamped = 16'(lim17);
        end

        if (idle_sample)
        begin
            new_entry = IDLE_ENTRY;
        end
        else
        begin
            new_entry.delta = clamped;
            new_entry.x     = touch_x;
            new_entry.y     = touch_y;
        end
    end

    // sequencer
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rotate   = (state_reg == ST_SCAN);
    assign shift    = accept || rotate;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        last_gesture_next = last_gesture_reg;
        out_valid_next    = out_valid_reg;
        gesture_next      = gesture_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RING_DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    gesture_next      = scan_result;
                    last_gesture_next = scan_result;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            last_gesture_reg <= GEST_NONE;
            out_valid_reg    <= 1'b0;
            gesture_reg      <= GEST_NONE;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            last_gesture_reg <= last_gesture_next;
            out_valid_reg    <= out_valid_next;
            gesture_reg      <= gesture_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;

    // cell chain, oldest slot drops out when a sample shifts in
    assign head_din = accept ? new_entry : chain[RING_DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < RING_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                tcgd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (head_din),
                    .dout  (chain[gi])
                );
            end
            else
            begin : g_body
                tcgd_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (chain[gi-1]),
                    .dout  (chain[gi])
                );
            end
        end
    endgenerate

    // accumulator watches the tail while the chain rotates
    assign scan_ctrl.clear = accept;
    assign scan_ctrl.step  = rotate;

    assign scan_cfg.turn_threshold = turn_threshold_reg;
    assign scan_cfg.min_axis_span  = min_axis_span_reg;
    assign scan_cfg.min_diag_span  = min_diag_span_reg;

    tcgd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .tail   (chain[RING_DEPTH-1]),
        .cfg    (scan_cfg),
        .result (scan_result)
    );

endmodule

`default_nettype wire

FILE: bench/touch_circle_gesture_detector_test.sv
// testbench for the circle gesture detector: gesture tracker, stimulus and result checks
`timescale 1ns / 100ps

module touch_circle_gesture_detector_test;

    import tcgd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    class gesture_tracker;
        logic [17:0]        turn_threshold;
        logic [14:0]        delta_clamp;
        logic [8:0]         min_axis_span;
        logic [9:0]         min_diag_span;
        logic signed [15:0] delta_ring [RING_DEPTH];
        logic [7:0]         ring_x [RING_DEPTH];
        logic [7:0]         ring_y [RING_DEPTH];
        int                 ring_pos;
        gesture_t           last_gesture;
        gesture_t           pending_gestures [$];
        int                 mismatches;

        function new();
            turn_threshold = TURN_THRESHOLD_RST;
            delta_clamp    = DELTA_CLAMP_RST;
            min_axis_span  = MIN_AXIS_SPAN_RST;
            min_diag_span  = MIN_DIAG_SPAN_RST;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                delta_ring[i] = '0;
                ring_x[i]     = CENTRE_X;
                ring_y[i]     = CENTRE_Y;
            end
            ring_pos     = 0;
            last_gesture = GEST_NONE;
            mismatches   = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [17:0] value);
            case (idx)
                CFG_TURN_THRESHOLD: turn_threshold = value;
                CFG_DELTA_CLAMP:    delta_clamp    = value[14:0];
                CFG_MIN_AXIS_SPAN:  min_axis_span  = value[8:0];
                CFG_MIN_DIAG_SPAN:  min_diag_span  = value[9:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_gestures.size();
        endfunction

        // one accepted input beat: update the ring and queue the gesture it yields
        function void take_sample(logic en, logic held, logic signed [15:0] now,
                                  logic signed [15:0] prev, logic [7:0] x, logic [7:0] y);
            logic signed [15:0] wrapped;
            int                 step_delta, lim, thr, total, px, py;
            int                 xmin, xmax, ymin, ymax, smin, smax, dmin, dmax;
            gesture_t           verdict;
            if (!en || !held || last_gesture != GEST_NONE)
            begin
                delta_ring[ring_pos] = '0;
                ring_x[ring_pos]     = CENTRE_X;
                ring_y[ring_pos]     = CENTRE_Y;
            end
            else
            begin
                wrapped    = now - prev;
                step_delta = wrapped;
                lim        = delta_clamp;
                if (step_delta < -lim)
                    step_delta = -lim;
                else if (step_delta > lim)
                    step_delta = lim;
                delta_ring[ring_pos] = 16'(step_delta);
                ring_x[ring_pos]     = x;
                ring_y[ring_pos]     = y;
            end
            ring_pos = (ring_pos + 1) % RING_DEPTH;

            total = 0;
            foreach (delta_ring[i])
                total += delta_ring[i];
            thr = turn_threshold;
            if (total < -thr)
                verdict = GEST_NEG;
            else if (total > thr)
                verdict = GEST_POS;
            else
                verdict = GEST_NONE;

            if (verdict != GEST_NONE)
            begin
                xmin = CENTRE_X;    xmax = CENTRE_X;
                ymin = CENTRE_Y;    ymax = CENTRE_Y;
                smin = SUM_CENTRE;  smax = SUM_CENTRE;
                dmin = DIFF_CENTRE; dmax = DIFF_CENTRE;
                foreach (ring_x[i])
                begin
                    px = ring_x[i];
                    py = ring_y[i];
                    if (px < xmin) xmin = px;
                    if (px > xmax) xmax = px;
                    if (py < ymin) ymin = py;
                    if (py > ymax) ymax = py;
                    if (px + py < smin) smin = px + py;
                    if (px + py > smax) smax = px + py;
                    if (px - py < dmin) dmin = px - py;
                    if (px - py > dmax) dmax = px - py;
                end
                if (xmax - xmin < int'(min_axis_span) || ymax - ymin < int'(min_axis_span) ||
                    smax - smin < int'(min_diag_span) || dmax - dmin < int'(min_diag_span))
                    verdict = GEST_NONE;
            end
            last_gesture = verdict;
            pending_gestures.push_back(verdict);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task match_gesture(logic [1:0] got);
            gesture_t want;
            if (pending_gestures.size() == 0)
                report($sformatf("gesture %0d with nothing expected", got));
            else
            begin
                want = pending_gestures.pop_front();
                if (got !== want)
                    report($sformatf("gesture %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               enable = 1'b0;
    logic               touch_held = 1'b0;
    logic signed [15:0] angle_now = '0;
    logic signed [15:0] angle_prev = '0;
    logic [7:0]         touch_x = '0;
    logic [7:0]         touch_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         gesture;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [17:0]        cfg_data = '0;

    gesture_tracker     sb;
    bit                 calm = 1'b0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int unsigned        cycle_count = 0;

    touch_circle_gesture_detector dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .enable     (enable),
        .touch_held (touch_held),
        .angle_now  (angle_now),
        .angle_prev (angle_prev),
        .touch_x    (touch_x),
        .touch_y    (touch_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .gesture    (gesture),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("touch_circle_gesture_detector_test NOT OK");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // cosine of k sixteenths of a turn, scaled by 64
    function automatic int cos64(int k);
        case (k & 15)
            0:       return 64;
            1, 15:   return 59;
            2, 14:   return 45;
            3, 13:   return 24;
            4, 12:   return 0;
            5, 11:   return -24;
            6, 10:   return -45;
            default: return -59 - ((k & 15) == 8 ? 5 : 0);
        endcase
    endfunction

    function automatic logic [7:0] to_pixel(int v);
        return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : 8'(v));
    endfunction

    // result side stalls, with the long hold-off taking priority
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = gap_len();
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.match_gesture(gesture);

    task automatic send_sample(logic en, logic held, logic [15:0] now, logic [15:0] prev,
                               logic [7:0] x, logic [7:0] y);
        int gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        enable     <= en;
        touch_held <= held;
        angle_now  <= now;
        angle_prev <= prev;
        touch_x    <= x;
        touch_y    <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_sample(en, held, now, prev, x, y);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [17:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [17:0] thr, logic [17:0] clamp, logic [17:0] axis,
                              logic [17:0] diag);
        settle();
        write_reg(CFG_TURN_THRESHOLD, thr);
        write_reg(CFG_DELTA_CLAMP, clamp);
        write_reg(CFG_MIN_AXIS_SPAN, axis);
        write_reg(CFG_MIN_DIAG_SPAN, diag);
    endtask

    // stylus stroke around a random centre, point taken from the angle's top bits
    task automatic trace_circle(input int break_pct, inout int sent);
        int          len, step, radius, cx, cy, k;
        logic [15:0] ang, prev_ang;
        logic        dir, en, held;
        len    = $urandom_range(6, 24);
        dir    = 1'($urandom_range(0, 1));
        step   = $urandom_range(1000, 16000);
        radius = $urandom_range(15, 110);
        cx     = $urandom_range(100, 156);
        cy     = $urandom_range(70, 122);
        ang    = 16'($urandom);
        repeat (len)
        begin
            prev_ang = ang;
            ang = 16'(int'(ang) + (dir ? step : -step) + int'($urandom_range(0, 600)) - 300);
            k = ang[15:12];
            en   = 1'b1;
            held = 1'b1;
            if ($urandom_range(0, 99) < break_pct)
            begin
                if ($urandom_range(0, 1) == 0)
                    en = 1'b0;
                else
                    held = 1'b0;
            end
            send_sample(en, held, ang, prev_ang,
                        to_pixel(cx + radius * cos64(k) / 64),
                        to_pixel(cy + radius * cos64(k - 4) / 64));
            sent++;
        end
    endtask

    task automatic random_phase(int count);
        int sent, pick;
        sent = 0;
        while (sent < count)
        begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                trace_circle(3, sent);
            else if (pick < 8)
                trace_circle(35, sent);
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_sample(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                                8'($urandom), 8'($urandom));
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    task automatic directed_samples();
        set_config(18'd20000, 18'd32767, 18'd0, 18'd0);
        // sum lands exactly on +threshold, then exactly on -threshold, then just past it
        send_sample(1'b1, 1'b1, 16'd20000, 16'd0, 8'd0, 8'd0);
        send_sample(1'b1, 1'b1, 16'h8001, 16'd0, 8'd255, 8'd255);
        send_sample(1'b1, 1'b1, 16'(-7233), 16'd0, 8'd255, 8'd0);
        send_sample(1'b1, 1'b1, 16'hFFFF, 16'd0, 8'd0, 8'd255);
        // beats forced to the centre entry while the spin is reported, until the sum drops back inside the threshold
        for (int i = 0; i < 12; i++)
            send_sample(i[0], i[1], i[2] ? 16'h7FFF : 16'h8000, i[3] ? 16'h8000 : 16'h7FFF,
                        i[0] ? 8'd255 : 8'd0, i[1] ? 8'd0 : 8'd255);
        // angle difference wrapping at the 16-bit boundary
        send_sample(1'b1, 1'b1, 16'h7FFF, 16'h8000, 8'd10, 8'd200);
        send_sample(1'b1, 1'b1, 16'h8000, 16'h7FFF, 8'd200, 8'd10);
        send_sample(1'b1, 1'b1, 16'h0000, 16'h8000, 8'd255, 8'd255);
        send_sample(1'b1, 1'b1, 16'h8000, 16'h8000, 8'd0, 8'd0);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        directed_samples();

        set_config(TURN_THRESHOLD_RST, DELTA_CLAMP_RST, MIN_AXIS_SPAN_RST, MIN_DIAG_SPAN_RST);
        random_phase(125);
        set_config(18'd0, 18'd32767, 18'd0, 18'd0);
        random_phase(125);
        set_config(18'h3FFFF, 18'd32767, 18'd511, 18'd1023);
        random_phase(125);
        set_config(18'($urandom_range(20000, 90000)), 18'($urandom_range(4000, 16000)),
                   18'($urandom_range(0, 100)), 18'($urandom_range(0, 160)));
        @(posedge clk);
        hold_left = 400;
        random_phase(125);
        set_config(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        random_phase(125);
        set_config(18'd131071, 18'd32767, 18'd30, 18'd40);
        random_phase(125);

        settle();
        repeat (40) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d gestures never delivered", sb.pending()));
        if (sb.mismatches == 0)
            $display("touch_circle_gesture_detector_test OK");
        else
            $display("touch_circle_gesture_detector_test NOT OK");
        $finish;
    end

endmodule
